// File: rtl/cmc_pkg.sv
// Package of the colour marker centroid block: constants, register codes,
// pixel and event types shared by its modules.
// Depends on nothing.
package cmc_pkg;

  // Default frame size limits, used as parameter defaults on the top level.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_THRESHOLD    = 2'd2,
    CFG_BORDER       = 2'd3
  } cfg_idx_e;

  // Reset values and limits of the configuration registers.
  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 360;
  localparam int THRESHOLD_RST    = 25;
  localparam int BORDER_RST       = 50;
  localparam int MIN_SIZE         = 16;
  localparam int MIN_BORDER       = 10;

  // Pixel and window geometry.
  localparam int CHAN_W     = 8;
  localparam int STORE_ROWS = 15;  // rows held in the row store
  localparam int SLOT_W     = 4;   // index of a row store slot
  localparam int TAP_OFFSET = 5;   // tested position lags the newest pixel by this much
  localparam int PIX_LAG    = 10;  // left tap: ten pixels back in the current row
  localparam int UP_TAPS    = 4;   // delay after the registered row store read

  // Result fields.
  localparam int CENTER_W = 11;
  localparam int HIT_W    = 21;
  localparam int HIT_MAX  = 2097151;

  // Depth of the event queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  // What the front has learnt about one pixel item.
  typedef struct packed {
    logic clear;  // frame restarts before this item
    logic hit;    // tested position is a marker hit
    logic last;   // item closes the frame
  } ev_flags_t;

  typedef enum logic {
    ST_ACC,
    ST_DIV
  } back_state_e;

endpackage

// File: rtl/cmc_div.sv
// Bit-serial restoring divider used for the end-of-frame means.
// Depends on nothing; the caller guarantees the quotient fits QuotW bits.
module cmc_div #(
  parameter int DivisorW = 21,
  parameter int QuotW    = 10,
  localparam int StepW   = $clog2(QuotW + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [DivisorW+QuotW-1:0] dividend_i,
  input  logic [DivisorW-1:0]       divisor_i,
  output logic                      done_o,
  output logic [QuotW-1:0]          quot_o
);

  logic [DivisorW-1:0] rem_q, rem_d;
  logic [DivisorW-1:0] div_q;
  logic [QuotW-1:0]    quo_q, quo_d;
  logic [StepW-1:0]    step_q;
  logic                busy_q;
  logic                done_q;
  logic [DivisorW:0]   trial;
  logic [DivisorW:0]   diff;
  logic                ge;

  // One quotient bit per cycle: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    trial = {rem_q, quo_q[QuotW-1]};
    diff  = trial - {1'b0, div_q};
    ge    = (trial >= {1'b0, div_q});
    rem_d = ge ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
    quo_d = {quo_q[QuotW-2:0], ge};
  end

  // Control: step counter and a done pulse after the last step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(QuotW);
      end else if (busy_q) begin
        step_q <= step_q - StepW'(1);
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath. The upper dividend part is already below the divisor, so only
  // the low QuotW bits need a step each.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[DivisorW+QuotW-1:QuotW];
      quo_q <= dividend_i[QuotW-1:0];
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// File: rtl/cmc_queue.sv
// Short register queue that carries classified pixel events from front to back.
// Depends on nothing.
module cmc_queue #(
  parameter int DataW = 24,
  parameter int Depth = 4,
  localparam int PtrW = $clog2(Depth),
  localparam int CntW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] data_i,
  input  logic             pop_i,
  output logic [DataW-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [DataW-1:0] store_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/cmc_front.sv
// Front of the colour marker centroid: raster position, row store, pixel
// delay lines and the per-position marker test. Depends on cmc_pkg.
module cmc_front import cmc_pkg::*; #(
  parameter int MaxWidth  = MAX_WIDTH,
  parameter int MaxHeight = MAX_HEIGHT,
  localparam int ColW     = $clog2(MaxWidth),
  localparam int RowW     = $clog2(MaxHeight)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  pixel_t            pix_i,
  input  logic              frame_start_i,
  input  logic [ColW:0]     width_i,
  input  logic [RowW:0]     height_i,
  input  logic [CHAN_W-1:0] threshold_i,
  input  logic [CHAN_W-1:0] border_i,
  output ev_flags_t         flags_o,
  output logic [ColW-1:0]   col_o,
  output logic [RowW-1:0]   row_o
);

  localparam int AddrW = $clog2(STORE_ROWS * MaxWidth);
  localparam int CmpW  = ((ColW > RowW) ? ColW : RowW) + 2;

  logic [ColW-1:0]   col_q, col_d, col_c;
  logic [RowW-1:0]   row_q, row_d, row_c;
  logic [SLOT_W-1:0] slot_q, slot_d, slot_c;
  logic [ColW:0]     col_inc;
  logic [RowW:0]     row_inc;
  logic              restart, last_col, last_row;
  logic [AddrW-1:0]  addr;
  logic [ColW-1:0]   pos_j;
  logic [RowW-1:0]   pos_i;
  logic              in_win, marker;

  pixel_t row_mem [STORE_ROWS * MaxWidth];
  pixel_t rd_q;
  pixel_t left_q [PIX_LAG];
  pixel_t up_q   [UP_TAPS];

  // The red channel above must beat both lower taps, blue must win on the
  // left tap and green on the right tap, each by more than the threshold.
  function automatic logic marker_hit(pixel_t up, pixel_t left, pixel_t right,
                                      logic [CHAN_W-1:0] t);
    logic [CHAN_W:0] tt;
    tt = {1'b0, t};
    return ({1'b0, up.red} > {1'b0, left.red} + tt)
        && ({1'b0, up.red} > {1'b0, right.red} + tt)
        && ({1'b0, left.blue} > {1'b0, up.blue} + tt)
        && ({1'b0, left.blue} > {1'b0, right.blue} + tt)
        && ({1'b0, right.green} > {1'b0, up.green} + tt)
        && ({1'b0, right.green} > {1'b0, left.green} + tt);
  endfunction

  // Position of this item; a frame start or a position outside a smaller
  // frame restarts the raster.
  always_comb begin
    restart = frame_start_i || ({1'b0, col_q} >= width_i) || ({1'b0, row_q} >= height_i);
    col_c   = restart ? '0 : col_q;
    row_c   = restart ? '0 : row_q;
    slot_c  = restart ? '0 : slot_q;
    addr    = AddrW'(slot_c) * AddrW'(MaxWidth) + AddrW'(col_c);
  end

  // Next raster position.
  always_comb begin
    col_inc  = (ColW+1)'(col_c) + (ColW+1)'(1);
    row_inc  = (RowW+1)'(row_c) + (RowW+1)'(1);
    last_col = (col_inc >= width_i);
    last_row = (row_inc >= height_i);
    col_d    = last_col ? '0 : col_inc[ColW-1:0];
    row_d    = row_c;
    slot_d   = slot_c;
    if (last_col) begin
      if (last_row) begin
        row_d  = '0;
        slot_d = '0;
      end else begin
        row_d  = row_inc[RowW-1:0];
        slot_d = (slot_c == SLOT_W'(STORE_ROWS - 1)) ? '0 : slot_c + SLOT_W'(1);
      end
    end
  end

  // Marker test of the position five rows and columns behind this pixel.
  always_comb begin
    pos_i  = row_c - RowW'(TAP_OFFSET);
    pos_j  = col_c - ColW'(TAP_OFFSET);
    in_win = (row_c >= RowW'(TAP_OFFSET)) && (col_c >= ColW'(TAP_OFFSET))
          && (CmpW'(pos_i) >= CmpW'(border_i))
          && (CmpW'(pos_i) + CmpW'(border_i) < CmpW'(height_i))
          && (CmpW'(pos_j) >= CmpW'(border_i))
          && (CmpW'(pos_j) + CmpW'(border_i) < CmpW'(width_i));
    marker = marker_hit(up_q[UP_TAPS-1], left_q[PIX_LAG-1], pix_i, threshold_i);
  end

  assign flags_o.clear = restart;
  assign flags_o.hit   = in_win && marker;
  assign flags_o.last  = last_col && last_row;
  assign col_o         = pos_j;
  assign row_o         = pos_i;

  // Raster position registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else if (accept_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
    end
  end

  // Row store: the pixel fifteen rows up is read as this one replaces it.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rd_q          <= row_mem[addr];
      row_mem[addr] <= pix_i;
    end
  end

  // Left tap delay and the delay behind the row store read.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      left_q[0] <= pix_i;
      for (int k = 1; k < PIX_LAG; k++) begin
        left_q[k] <= left_q[k-1];
      end
      up_q[0] <= rd_q;
      for (int k = 1; k < UP_TAPS; k++) begin
        up_q[k] <= up_q[k-1];
      end
    end
  end

endmodule

// File: rtl/cmc_back.sv
// Back of the colour marker centroid: hit accumulators, end-of-frame means
// through two serial dividers, and the result register. Depends on cmc_pkg, cmc_div.
module cmc_back import cmc_pkg::*; #(
  parameter int MaxWidth  = MAX_WIDTH,
  parameter int MaxHeight = MAX_HEIGHT,
  localparam int ColW     = $clog2(MaxWidth),
  localparam int RowW     = $clog2(MaxHeight)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       ev_valid_i,
  input  ev_flags_t                  ev_flags_i,
  input  logic [ColW-1:0]            ev_col_i,
  input  logic [RowW-1:0]            ev_row_i,
  output logic                       ev_pop_o,
  input  logic                       res_pop_i,
  output logic                       res_empty_o,
  output logic signed [CENTER_W-1:0] center_col_o,
  output logic signed [CENTER_W-1:0] center_row_o,
  output logic [HIT_W-1:0]           hit_count_o,
  output logic                       found_o
);

  localparam int CntW    = $clog2(MaxWidth * MaxHeight + 1);
  localparam int QuotW   = (ColW > RowW) ? ColW : RowW;
  localparam int DivW    = CntW + QuotW;
  localparam int ColSumW = CntW + ColW;
  localparam int RowSumW = CntW + RowW;
  localparam int SatW    = (CntW > HIT_W) ? CntW : HIT_W;
  localparam int ExtW    = (QuotW > CENTER_W) ? QuotW : CENTER_W;

  back_state_e        state_q, state_d;
  logic [ColSumW-1:0] col_sum_q, col_sum_new;
  logic [RowSumW-1:0] row_sum_q, row_sum_new;
  logic [CntW-1:0]    cnt_q, cnt_new, cnt_lat_q;
  logic               take_end, end_now, div_start, load_none, load_div;
  logic               col_done, row_done;
  logic [QuotW-1:0]   col_quot, row_quot;
  logic [SatW-1:0]    cnt_ext;
  logic [HIT_W-1:0]   cnt_sat;
  logic [ExtW-1:0]    col_ext, row_ext;

  logic signed [CENTER_W-1:0] res_col_q, res_row_q;
  logic [HIT_W-1:0]           res_cnt_q;
  logic                       res_found_q;
  logic                       res_valid_q;

  // Sums after this event; a restart clears them first.
  always_comb begin
    col_sum_new = (ev_flags_i.clear ? '0 : col_sum_q)
                + (ev_flags_i.hit ? ColSumW'(ev_col_i) : '0);
    row_sum_new = (ev_flags_i.clear ? '0 : row_sum_q)
                + (ev_flags_i.hit ? RowSumW'(ev_row_i) : '0);
    cnt_new     = (ev_flags_i.clear ? '0 : cnt_q) + CntW'(ev_flags_i.hit);
  end

  // Next state: dividing runs from a frame end with hits to the done pulse.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_ACC: begin
        if (div_start) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (col_done) begin
          state_d = ST_ACC;
        end
      end
      default: state_d = ST_ACC;
    endcase
  end

  // Controls. A frame end waits for free dividers and an empty result slot.
  always_comb begin
    take_end  = (state_q == ST_ACC) && !res_valid_q;
    ev_pop_o  = ev_valid_i && (!ev_flags_i.last || take_end);
    end_now   = ev_pop_o && ev_flags_i.last;
    div_start = end_now && (cnt_new != '0);
    load_none = end_now && (cnt_new == '0);
    load_div  = (state_q == ST_DIV) && col_done;
  end

  // State, accumulators and the result slot's valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      col_sum_q   <= '0;
      row_sum_q   <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ev_pop_o) begin
        if (ev_flags_i.last) begin
          col_sum_q <= '0;
          row_sum_q <= '0;
          cnt_q     <= '0;
        end else begin
          col_sum_q <= col_sum_new;
          row_sum_q <= row_sum_new;
          cnt_q     <= cnt_new;
        end
      end
      if (load_none || load_div) begin
        res_valid_q <= 1'b1;
      end else if (res_pop_i && res_valid_q) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Means of the closed frame.
  cmc_div #(
    .DivisorW (CntW),
    .QuotW    (QuotW)
  ) u_col_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DivW'(col_sum_new)),
    .divisor_i  (cnt_new),
    .done_o     (col_done),
    .quot_o     (col_quot)
  );

  cmc_div #(
    .DivisorW (CntW),
    .QuotW    (QuotW)
  ) u_row_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DivW'(row_sum_new)),
    .divisor_i  (cnt_new),
    .done_o     (row_done),
    .quot_o     (row_quot)
  );

  // Count saturates; means keep their low bits.
  always_comb begin
    cnt_ext = SatW'(cnt_lat_q);
    cnt_sat = (cnt_ext > SatW'(HIT_MAX)) ? HIT_W'(HIT_MAX) : cnt_ext[HIT_W-1:0];
    col_ext = ExtW'(col_quot);
    row_ext = ExtW'(row_quot);
  end

  // Result payload; both dividers finish on the same cycle.
  always_ff @(posedge clk_i) begin
    if (div_start) begin
      cnt_lat_q <= cnt_new;
    end
    if (load_none) begin
      res_col_q   <= '1;
      res_row_q   <= '1;
      res_cnt_q   <= '0;
      res_found_q <= 1'b0;
    end else if (load_div && row_done) begin
      res_col_q   <= col_ext[CENTER_W-1:0];
      res_row_q   <= row_ext[CENTER_W-1:0];
      res_cnt_q   <= cnt_sat;
      res_found_q <= 1'b1;
    end
  end

  assign res_empty_o  = !res_valid_q;
  assign center_col_o = res_col_q;
  assign center_row_o = res_row_q;
  assign hit_count_o  = res_cnt_q;
  assign found_o      = res_found_q;

endmodule

// File: rtl/color_marker_centroid.sv
// Top level of the colour marker centroid: configuration registers, front,
// event queue and back. Depends on cmc_pkg, cmc_front, cmc_queue, cmc_back.
//
// Finds a three-colour marker in a raster pixel stream and reports the mean
// column and row of all hit positions once per frame. The front takes one
// pixel item per clock for as long as the four-entry event queue has room;
// the back retires one event per clock unless a frame end is held, so full
// stays low in steady streaming. The test of position (i,j) is made when
// pixel (i+5,j+5) arrives, against a single-port row store of 15 x MaxWidth
// pixels read and written once per item. After the last event of a frame
// reaches the back, its means come from the two bit-serial dividers, QuotW
// quotient bits each (QuotW = clog2 of the larger frame limit, 10 by default);
// a frame without hits reports at once. The back keeps accumulating the next
// frame meanwhile; a frame end is held in the queue while the dividers run or
// the previous result waits to be popped, and full rises when the queue fills
// behind it. Writes clamp frame sizes to 16..limit, the border to at least 10.
module color_marker_centroid import cmc_pkg::*; #(
  parameter int MaxWidth  = MAX_WIDTH,
  parameter int MaxHeight = MAX_HEIGHT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       push,
  output logic                       full,
  input  logic [CHAN_W-1:0]          chan_blue_i,
  input  logic [CHAN_W-1:0]          chan_green_i,
  input  logic [CHAN_W-1:0]          chan_red_i,
  input  logic                       frame_start_i,
  input  logic                       pop,
  output logic                       empty,
  output logic signed [CENTER_W-1:0] center_col_o,
  output logic signed [CENTER_W-1:0] center_row_o,
  output logic [HIT_W-1:0]           hit_count_o,
  output logic                       found_o
);

  localparam int ColW     = $clog2(MaxWidth);
  localparam int RowW     = $clog2(MaxHeight);
  localparam int QDataW   = $bits(ev_flags_t) + ColW + RowW;
  localparam int WidthRst = (FRAME_WIDTH_RST > MaxWidth) ? MaxWidth : FRAME_WIDTH_RST;
  localparam int HeightRst = (FRAME_HEIGHT_RST > MaxHeight) ? MaxHeight : FRAME_HEIGHT_RST;

  logic [ColW:0]       width_q, width_clamp;
  logic [RowW:0]       height_q, height_clamp;
  logic [CHAN_W-1:0]   threshold_q, border_q, border_clamp;
  pixel_t              pix;
  logic                accept;
  ev_flags_t           fr_flags, q_flags;
  logic [ColW-1:0]     fr_col, q_col;
  logic [RowW-1:0]     fr_row, q_row;
  logic [QDataW-1:0]   q_data;
  logic                q_empty, q_pop;

  // Clamp written values into the supported ranges.
  always_comb begin
    if (cfg_data_i < CFG_DATA_W'(MIN_SIZE)) begin
      width_clamp = (ColW+1)'(MIN_SIZE);
    end else if (int'(cfg_data_i) > MaxWidth) begin
      width_clamp = (ColW+1)'(MaxWidth);
    end else begin
      width_clamp = (ColW+1)'(cfg_data_i);
    end
    if (cfg_data_i < CFG_DATA_W'(MIN_SIZE)) begin
      height_clamp = (RowW+1)'(MIN_SIZE);
    end else if (int'(cfg_data_i) > MaxHeight) begin
      height_clamp = (RowW+1)'(MaxHeight);
    end else begin
      height_clamp = (RowW+1)'(cfg_data_i);
    end
    border_clamp = (cfg_data_i[CHAN_W-1:0] < CHAN_W'(MIN_BORDER)) ?
                   CHAN_W'(MIN_BORDER) : cfg_data_i[CHAN_W-1:0];
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= (ColW+1)'(WidthRst);
      height_q    <= (RowW+1)'(HeightRst);
      threshold_q <= CHAN_W'(THRESHOLD_RST);
      border_q    <= CHAN_W'(BORDER_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_WIDTH:  width_q     <= width_clamp;
        CFG_FRAME_HEIGHT: height_q    <= height_clamp;
        CFG_THRESHOLD:    threshold_q <= cfg_data_i[CHAN_W-1:0];
        CFG_BORDER:       border_q    <= border_clamp;
        default: ;
      endcase
    end
  end

  // Input item handshake.
  always_comb begin
    pix.red   = chan_red_i;
    pix.green = chan_green_i;
    pix.blue  = chan_blue_i;
  end
  assign accept = push && !full;

  cmc_front #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .pix_i         (pix),
    .frame_start_i (frame_start_i),
    .width_i       (width_q),
    .height_i      (height_q),
    .threshold_i   (threshold_q),
    .border_i      (border_q),
    .flags_o       (fr_flags),
    .col_o         (fr_col),
    .row_o         (fr_row)
  );

  cmc_queue #(
    .DataW (QDataW),
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  ({fr_flags, fr_col, fr_row}),
    .pop_i   (q_pop),
    .data_o  (q_data),
    .full_o  (full),
    .empty_o (q_empty)
  );

  assign {q_flags, q_col, q_row} = q_data;

  cmc_back #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ev_valid_i   (!q_empty),
    .ev_flags_i   (q_flags),
    .ev_col_i     (q_col),
    .ev_row_i     (q_row),
    .ev_pop_o     (q_pop),
    .res_pop_i    (pop),
    .res_empty_o  (empty),
    .center_col_o (center_col_o),
    .center_row_o (center_row_o),
    .hit_count_o  (hit_count_o),
    .found_o      (found_o)
  );

endmodule

// File: rtl/cmc_checker.sv
// Port-level checks of the colour marker centroid, bound to the top level.
// Depends on cmc_pkg and color_marker_centroid.
module cmc_checker import cmc_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       push,
  input logic                       full,
  input logic                       pop,
  input logic                       empty,
  input logic signed [CENTER_W-1:0] center_col_o,
  input logic signed [CENTER_W-1:0] center_row_o,
  input logic [HIT_W-1:0]           hit_count_o,
  input logic                       found_o
);

  // A waiting result stays until it is popped.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("result withdrawn before pop");

  // A waiting result does not change.
  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(center_col_o) && $stable(center_row_o)
                    && $stable(hit_count_o) && $stable(found_o))
    else $error("waiting result changed");

  // Found means at least one hit was counted.
  a_found_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (found_o == (hit_count_o != '0)))
    else $error("found flag disagrees with hit count");

  // A frame without hits reports minus one for both coordinates.
  a_none_centre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !found_o |-> (&center_col_o) && (&center_row_o))
    else $error("empty frame without minus one centre");

endmodule

bind color_marker_centroid cmc_checker u_cmc_checker (.*);
